// ===== src/bsf_pkg.sv =====
// Package for the bit store with first-clear search.
// Holds the item and result types, operation codes, controller commands
// and the priority encoder function. No dependencies.
package bsf_pkg;

	localparam int WORD_BITS   = 32;
	localparam int STORE_WORDS = 32;
	localparam int WORD_IDX_W  = 5;
	localparam int BIT_POS_W   = 5;
	localparam int INDEX_W     = 10;
	localparam int SIZE_W      = 11;
	localparam int SIZE_WORDS_W = 6;
	localparam int KIND_W      = 3;
	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;

	localparam logic [KIND_W-1:0] KIND_TEST      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SET       = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_FIND      = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLEAR_ALL = 3'd4;

	localparam logic REG_BITS_IN_USE = 1'b0;
	localparam logic [SIZE_W-1:0] BITS_IN_USE_RESET = 11'd1024;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [INDEX_W-1:0] bit_index;
	} item_t;

	typedef struct packed {
		logic               bit_value;
		logic               found;
		logic [INDEX_W-1:0] free_index;
		logic               index_error;
	} result_t;

	typedef struct packed {
		logic load;
		logic access;
		logic scan;
	} cmd_t;

	typedef struct packed {
		logic is_find;
	} status_t;

	function automatic logic [WORD_IDX_W-1:0] first_one(input logic [WORD_BITS-1:0] v);
		logic [WORD_IDX_W-1:0] pos;
		pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				pos = WORD_IDX_W'(i);
			end
		end
		return pos;
	endfunction

endpackage

// ===== src/bsf_ctrl.sv =====
// Controller state machine for the bit store.
// Sequences item load, word access and the second find step.
// Depends on bsf_pkg.
module bsf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  bsf_pkg::status_t status,
	output logic             busy,
	output bsf_pkg::cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_ACCESS = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.access = 1'b0;
		cmd.scan   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				cmd.access = 1'b1;
				state_d    = status.is_find ? ST_SCAN : ST_IDLE;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/bsf_datapath.sv =====
// Datapath for the bit store: word array with valid and full summary bits,
// word and bit priority encoders, and the result register.
// Depends on bsf_pkg.
module bsf_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bsf_pkg::cmd_t                  cmd,
	input  bsf_pkg::item_t                 item,
	input  logic [bsf_pkg::SIZE_W-1:0]     bits_in_use,
	output bsf_pkg::status_t               status,
	output logic                           done,
	output bsf_pkg::result_t               result
);

	logic [bsf_pkg::KIND_W-1:0]       kind_q;
	logic [bsf_pkg::INDEX_W-1:0]      idx_q;
	logic [bsf_pkg::WORD_BITS-1:0]    words_q [bsf_pkg::STORE_WORDS];
	logic [bsf_pkg::STORE_WORDS-1:0]  valid_q;
	logic [bsf_pkg::STORE_WORDS-1:0]  full_q;
	logic [bsf_pkg::WORD_IDX_W-1:0]   hit_word_q;
	logic                             hit_any_q;
	logic                             done_q;
	bsf_pkg::result_t                 result_q;

	logic [bsf_pkg::SIZE_WORDS_W-1:0] raw_words;
	logic [bsf_pkg::SIZE_WORDS_W-1:0] size_words;
	logic [bsf_pkg::WORD_IDX_W-1:0]   word_sel;
	logic [bsf_pkg::WORD_BITS-1:0]    rd_word;
	logic [bsf_pkg::WORD_BITS-1:0]    mask;
	logic [bsf_pkg::WORD_BITS-1:0]    wr_word;
	logic [bsf_pkg::STORE_WORDS-1:0]  candidate;
	logic                             in_range;
	logic                             wr_en;
	logic                             clear_all;
	bsf_pkg::result_t                 res_d;

	assign raw_words  = bits_in_use[bsf_pkg::SIZE_W-1:bsf_pkg::BIT_POS_W];
	assign size_words = (raw_words > bsf_pkg::SIZE_WORDS_W'(bsf_pkg::STORE_WORDS)) ?
		bsf_pkg::SIZE_WORDS_W'(bsf_pkg::STORE_WORDS) : raw_words;

	assign word_sel = cmd.scan ? hit_word_q : idx_q[bsf_pkg::INDEX_W-1:bsf_pkg::BIT_POS_W];
	assign rd_word  = valid_q[word_sel] ? words_q[word_sel] : '0;
	assign in_range = ({1'b0, idx_q[bsf_pkg::INDEX_W-1:bsf_pkg::BIT_POS_W]} < size_words);
	assign mask     = bsf_pkg::WORD_BITS'(1) << idx_q[bsf_pkg::BIT_POS_W-1:0];

	always_comb begin
		for (int w = 0; w < bsf_pkg::STORE_WORDS; w++) begin
			candidate[w] = !full_q[w] && (bsf_pkg::SIZE_WORDS_W'(w) < size_words);
		end
	end

	always_comb begin
		res_d     = '0;
		wr_en     = 1'b0;
		wr_word   = rd_word;
		clear_all = 1'b0;
		if (cmd.scan) begin
			res_d.found = hit_any_q;
			if (hit_any_q) begin
				res_d.free_index = {hit_word_q, bsf_pkg::first_one(~rd_word)};
			end
		end else if (cmd.access) begin
			case (kind_q)
				bsf_pkg::KIND_TEST: begin
					res_d.index_error = !in_range;
					res_d.bit_value   = in_range && rd_word[idx_q[bsf_pkg::BIT_POS_W-1:0]];
				end
				bsf_pkg::KIND_SET: begin
					res_d.index_error = !in_range;
					wr_en             = in_range;
					wr_word           = rd_word | mask;
				end
				bsf_pkg::KIND_CLEAR: begin
					res_d.index_error = !in_range;
					wr_en             = in_range;
					wr_word           = rd_word & ~mask;
				end
				bsf_pkg::KIND_CLEAR_ALL: begin
					clear_all = 1'b1;
				end
				default: begin
					res_d = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= item.kind;
			idx_q  <= item.bit_index;
		end
		if (wr_en) begin
			words_q[word_sel] <= wr_word;
		end
		if (cmd.access) begin
			hit_word_q <= bsf_pkg::first_one(candidate);
			hit_any_q  <= |candidate;
		end
		if (cmd.scan || (cmd.access && kind_q != bsf_pkg::KIND_FIND)) begin
			result_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			full_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.scan || (cmd.access && kind_q != bsf_pkg::KIND_FIND);
			if (clear_all) begin
				valid_q <= '0;
				full_q  <= '0;
			end else if (wr_en) begin
				valid_q[word_sel] <= 1'b1;
				full_q[word_sel]  <= &wr_word;
			end
		end
	end

	assign status.is_find = (kind_q == bsf_pkg::KIND_FIND);
	assign done           = done_q;
	assign result         = result_q;

endmodule

// ===== src/bitmap_store_find_first_clear.sv =====
// Top level of the bit store with first-clear search.
// Holds the APB size register and joins bsf_ctrl and bsf_datapath.
// Depends on bsf_pkg, bsf_ctrl and bsf_datapath.
//
//   Channel   Handshake                         Payload
//   item      start high while busy low         item (kind, bit_index)
//   result    done high for one cycle           result (bit_value, found, ...)
//   config    psel, penable, pwrite, pready     pwdata, paddr, prdata
//
// Test, set, clear, clear all and unused kinds finish in the access step;
// find adds a scan step: access registers the word summary encoder's pick
// and scan runs the bit encoder on the selected word.
// A new item is accepted in the cycle in which the previous result shows.
// After reset the store reads all zero and bits_in_use is 1024.
// The receiver cannot stall; each result is shown for exactly one cycle.
module bitmap_store_find_first_clear (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  bsf_pkg::item_t                item,
	output logic                          done,
	output bsf_pkg::result_t              result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bsf_pkg::ADDR_W-1:0]    paddr,
	input  logic [bsf_pkg::DATA_W-1:0]    pwdata,
	output logic [bsf_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	logic [bsf_pkg::SIZE_W-1:0] bits_in_use_q;
	logic                       reg_hit;
	bsf_pkg::cmd_t              cmd;
	bsf_pkg::status_t           status;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[bsf_pkg::ADDR_W-1] == bsf_pkg::REG_BITS_IN_USE);
	assign prdata  = reg_hit ?
		{{(bsf_pkg::DATA_W - bsf_pkg::SIZE_W){1'b0}}, bits_in_use_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_in_use_q <= bsf_pkg::BITS_IN_USE_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			bits_in_use_q <= pwdata[bsf_pkg::SIZE_W-1:0];
		end
	end

	bsf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	bsf_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.item        (item),
		.bits_in_use (bits_in_use_q),
		.status      (status),
		.done        (done),
		.result      (result)
	);

endmodule

// ===== src/bsf_checker.sv =====
// Port-level checker for the bit store and its bind to the top level.
// Depends on bsf_pkg and bitmap_store_find_first_clear.
module bsf_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input bsf_pkg::result_t result
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an accepted item");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while the block is busy");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.index_error |-> !result.found && !result.bit_value &&
			result.free_index == '0)
		else $error("index error result carries other fields");

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.found |-> result.free_index == '0)
		else $error("free index nonzero without found");

endmodule

bind bitmap_store_find_first_clear bsf_checker u_bsf_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
